[src/lesf_pkg.sv]
// ----------------------------------------------------------------------------
// lesf_pkg
// shared types and constants of the largest empty square finder
// ----------------------------------------------------------------------------
package lesf_pkg;

   // request beat layout
   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned BLOCKED_BIT = 0;

   // per-cell control travelling from the scan stage to the update stage
   typedef struct packed {
      logic blocked;   // obstacle in this cell
      logic last;      // final cell of the grid
      logic border;    // first row or first column
      logic wrap;      // row ends after this cell
   } lesf_cell_ctl_type;

endpackage

[src/lesf_line_buf.sv]
// ----------------------------------------------------------------------------
// lesf_line_buf
// one-row line buffer of square sizes, one read and one write port,
// registered read data with write-to-read forwarding
// ----------------------------------------------------------------------------
module lesf_line_buf #(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10,
   parameter int unsigned DATA_W = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] q_ff;
   logic [DATA_W-1:0] fwd_ff;
   logic [DATA_W-1:0] fwd_in;
   logic              hit_ff;
   logic              hit_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   // a read that meets a write to the same entry takes the new value
   always_comb begin
      hit_in = hit_ff;
      fwd_in = fwd_ff;
      if (rd_en) begin
         hit_in = wr_en && (wr_addr == rd_addr);
         fwd_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff <= fwd_in;
   end

   assign rd_data = hit_ff ? fwd_ff : q_ff;

endmodule

[src/lesf_scan.sv]
// ----------------------------------------------------------------------------
// lesf_scan
// column count register, grid position tracking and the cell stage
// that lines up with the line buffer read
// ----------------------------------------------------------------------------
module lesf_scan #(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 4096,
   parameter int unsigned COL_W       = 10,
   parameter int unsigned ROW_W       = 12,
   parameter int unsigned SIZE_W      = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [SIZE_W-1:0]          csr_wr_data,
   input  logic                       accept,
   input  logic                       cell_blocked,
   input  logic                       last_cell,
   input  logic                       cell_go,
   output logic [COL_W-1:0]           rd_col,
   output logic                       cell_valid,
   output lesf_pkg::lesf_cell_ctl_type cell_ctl,
   output logic [ROW_W-1:0]           cell_row,
   output logic [COL_W-1:0]           cell_col
);
   import lesf_pkg::*;

   logic [SIZE_W-1:0]  cols_ff;
   logic [SIZE_W-1:0]  cols_in;
   logic [SIZE_W-1:0]  cols_eff;
   logic [SIZE_W-1:0]  col_next;
   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic               wrap;
   logic               valid_ff;
   logic               valid_in;
   lesf_cell_ctl_type  ctl_ff;
   lesf_cell_ctl_type  ctl_in;
   logic [ROW_W-1:0]   crow_ff;
   logic [ROW_W-1:0]   crow_in;
   logic [COL_W-1:0]   ccol_ff;
   logic [COL_W-1:0]   ccol_in;

   assign cols_in = csr_wr_en ? csr_wr_data : cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= SIZE_W'(1);
      end else begin
         cols_ff <= cols_in;
      end
   end

   // zero counts as one, large counts clamp to the buffer depth
   always_comb begin
      priority if (cols_ff == '0) begin
         cols_eff = SIZE_W'(1);
      end else if (cols_ff > SIZE_W'(MAX_COLUMNS)) begin
         cols_eff = SIZE_W'(MAX_COLUMNS);
      end else begin
         cols_eff = cols_ff;
      end
   end

   assign col_next = SIZE_W'(col_ff) + SIZE_W'(1);
   assign wrap     = (col_next >= cols_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         priority if (last_cell) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            if (row_ff < ROW_W'(MAX_ROWS - 1)) begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      ctl_in   = ctl_ff;
      crow_in  = crow_ff;
      ccol_in  = ccol_ff;
      if (accept) begin
         valid_in       = 1'b1;
         ctl_in.blocked = cell_blocked;
         ctl_in.last    = last_cell;
         ctl_in.border  = (row_ff == '0) || (col_ff == '0);
         ctl_in.wrap    = wrap;
         crow_in        = row_ff;
         ccol_in        = col_ff;
      end else if (cell_go) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff  <= ctl_in;
      crow_ff <= crow_in;
      ccol_ff <= ccol_in;
   end

   assign rd_col     = col_ff;
   assign cell_valid = valid_ff;
   assign cell_ctl   = ctl_ff;
   assign cell_row   = crow_ff;
   assign cell_col   = ccol_ff;

   row_saturates: assert property (@(posedge clock) disable iff (reset)
      row_ff <= ROW_W'(MAX_ROWS - 1))
      else $error("row index passed its limit");

endmodule

[src/lesf_update.sv]
// ----------------------------------------------------------------------------
// lesf_update
// size update of one cell, left and diagonal registers, best square
// tracking and the result register
// ----------------------------------------------------------------------------
module lesf_update #(
   parameter int unsigned COL_W  = 10,
   parameter int unsigned ROW_W  = 12,
   parameter int unsigned SIZE_W = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cell_valid,
   input  lesf_pkg::lesf_cell_ctl_type cell_ctl,
   input  logic [ROW_W-1:0]           cell_row,
   input  logic [COL_W-1:0]           cell_col,
   input  logic [SIZE_W-1:0]          up_size,
   output logic                       cell_go,
   output logic                       in_ready,
   output logic                       wr_en,
   output logic [COL_W-1:0]           wr_addr,
   output logic [SIZE_W-1:0]          wr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [SIZE_W-1:0]          square_size,
   output logic [ROW_W-1:0]           bottom_row,
   output logic [COL_W-1:0]           right_column
);
   import lesf_pkg::*;

   logic [SIZE_W-1:0] left_ff;
   logic [SIZE_W-1:0] left_in;
   logic [SIZE_W-1:0] diag_ff;
   logic [SIZE_W-1:0] diag_in;
   logic [SIZE_W-1:0] best_size_ff;
   logic [SIZE_W-1:0] best_size_in;
   logic [ROW_W-1:0]  best_row_ff;
   logic [ROW_W-1:0]  best_row_in;
   logic [COL_W-1:0]  best_col_ff;
   logic [COL_W-1:0]  best_col_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [SIZE_W-1:0] out_size_ff;
   logic [SIZE_W-1:0] out_size_in;
   logic [ROW_W-1:0]  out_row_ff;
   logic [ROW_W-1:0]  out_row_in;
   logic [COL_W-1:0]  out_col_ff;
   logic [COL_W-1:0]  out_col_in;
   logic [SIZE_W-1:0] min_ul;
   logic [SIZE_W-1:0] min_all;
   logic [SIZE_W-1:0] size;
   logic              better;
   logic              out_full;

   assign min_ul  = (left_ff < up_size) ? left_ff : up_size;
   assign min_all = (diag_ff < min_ul) ? diag_ff : min_ul;

   always_comb begin
      priority if (cell_ctl.blocked) begin
         size = '0;
      end else if (cell_ctl.border) begin
         size = SIZE_W'(1);
      end else begin
         size = min_all + SIZE_W'(1);
      end
   end

   assign better   = (size > best_size_ff);
   assign out_full = out_valid_ff && !rsp_ready;
   // only a last cell waits for room in the result register
   assign cell_go  = cell_valid && !(cell_ctl.last && out_full);
   assign in_ready = !cell_valid || cell_go;

   assign wr_en   = cell_go;
   assign wr_addr = cell_col;
   assign wr_data = size;

   always_comb begin
      left_in      = left_ff;
      diag_in      = diag_ff;
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      if (cell_go) begin
         if (cell_ctl.wrap || cell_ctl.last) begin
            left_in = '0;
            diag_in = '0;
         end else begin
            left_in = size;
            diag_in = up_size;
         end
         priority if (cell_ctl.last) begin
            best_size_in = '0;
            best_row_in  = '0;
            best_col_in  = '0;
         end else if (better) begin
            best_size_in = size;
            best_row_in  = cell_row;
            best_col_in  = cell_col;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_size_in  = out_size_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      if (cell_go && cell_ctl.last) begin
         out_valid_in = 1'b1;
         out_size_in  = better ? size     : best_size_ff;
         out_row_in   = better ? cell_row : best_row_ff;
         out_col_in   = better ? cell_col : best_col_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         diag_ff      <= '0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         diag_ff      <= diag_in;
         best_size_ff <= best_size_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_size_ff <= out_size_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign square_size  = out_size_ff;
   assign bottom_row   = out_row_ff;
   assign right_column = out_col_ff;

   best_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      cell_go && cell_ctl.last |=> best_size_ff == '0 && left_ff == '0 && diag_ff == '0)
      else $error("grid state not cleared after last cell");

   result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(cell_go && cell_ctl.last))
      else $error("result raised without a last cell");

   stalled_cell_held: assert property (@(posedge clock) disable iff (reset)
      cell_valid && !cell_go |=> cell_valid && $stable(cell_col) && $stable(cell_row))
      else $error("stalled cell lost");

endmodule

[src/largest_empty_square_finder_top.sv]
// Result: the tlast cell passes the cell stage and result registers to rsp.
// Throughput: one cell per cycle; the line buffer read at accept and the
//    write-back from the cell stage keep that rate through forwarding. A last
//    cell stalls the input only while the previous result is still not taken.
// Reset: synchronous; control, grid state and column count (to 1) reset,
//    the line buffer keeps its contents.
// ----------------------------------------------------------------------------
// largest_empty_square_finder_top
// streams a grid one cell per beat and reports the largest empty square
// ----------------------------------------------------------------------------
module largest_empty_square_finder_top #(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 4096,
   localparam int unsigned COL_W      = $clog2(MAX_COLUMNS),
   localparam int unsigned ROW_W      = $clog2(MAX_ROWS),
   localparam int unsigned SIZE_W     = COL_W + 1,
   localparam int unsigned RSP_DATA_W = ((SIZE_W + ROW_W + COL_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [SIZE_W-1:0]                 csr_wr_data,   // column_count
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lesf_pkg::REQ_DATA_W-1:0]   req_tdata,     // cell_blocked
   input  logic                              req_tlast,     // last_cell
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_DATA_W-1:0]             rsp_tdata      // square_size, bottom_row,
                                                            // right_column, zero pad
);
   import lesf_pkg::*;

   logic              accept;
   logic              cell_go;
   logic              in_ready;
   logic [COL_W-1:0]  rd_col;
   logic              cell_valid;
   lesf_cell_ctl_type cell_ctl;
   logic [ROW_W-1:0]  cell_row;
   logic [COL_W-1:0]  cell_col;
   logic [SIZE_W-1:0] up_size;
   logic              wr_en;
   logic [COL_W-1:0]  wr_addr;
   logic [SIZE_W-1:0] wr_data;
   logic [SIZE_W-1:0] square_size;
   logic [ROW_W-1:0]  bottom_row;
   logic [COL_W-1:0]  right_column;

   assign req_tready = in_ready;
   assign accept     = req_tvalid && in_ready;

   lesf_scan #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .COL_W       (COL_W),
      .ROW_W       (ROW_W),
      .SIZE_W      (SIZE_W)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .accept       (accept),
      .cell_blocked (req_tdata[BLOCKED_BIT]),
      .last_cell    (req_tlast),
      .cell_go      (cell_go),
      .rd_col       (rd_col),
      .cell_valid   (cell_valid),
      .cell_ctl     (cell_ctl),
      .cell_row     (cell_row),
      .cell_col     (cell_col)
   );

   lesf_line_buf #(
      .DEPTH  (MAX_COLUMNS),
      .ADDR_W (COL_W),
      .DATA_W (SIZE_W)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_col),
      .rd_data (up_size),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lesf_update #(
      .COL_W  (COL_W),
      .ROW_W  (ROW_W),
      .SIZE_W (SIZE_W)
   ) u_update (
      .clock        (clock),
      .reset        (reset),
      .cell_valid   (cell_valid),
      .cell_ctl     (cell_ctl),
      .cell_row     (cell_row),
      .cell_col     (cell_col),
      .up_size      (up_size),
      .cell_go      (cell_go),
      .in_ready     (in_ready),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .square_size  (square_size),
      .bottom_row   (bottom_row),
      .right_column (right_column)
   );

   assign rsp_tdata = RSP_DATA_W'({right_column, bottom_row, square_size});

endmodule

[bench/tb_largest_empty_square_finder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_largest_empty_square_finder_top
// streams grids cell by cell, takes each expected report from the plan or from
// the bench's own prediction, and checks every report beat field by field against it
// ----------------------------------------------------------------------------
module tb_largest_empty_square_finder_top;
   import lesf_pkg::*;

   localparam int unsigned MAX_COLUMNS  = 1024;
   localparam int unsigned MAX_ROWS     = 4096;
   localparam int unsigned COL_W        = 10;
   localparam int unsigned ROW_W        = 12;
   localparam int unsigned SIZE_W       = 11;
   localparam int unsigned RSP_DATA_W   = 40;
   localparam int          LIMIT_CYCLES = 600000;
   localparam int          HOLD_CYCLES  = 400;

   // first member lands in the top bits, so size ends up at bit 0
   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic [SIZE_W-1:0] size;
   } square_type;

   typedef enum int {
      FILL_OPEN,       // every cell free
      FILL_WALLED,     // every cell blocked
      FILL_LAST_OPEN,  // only the final cell free
      FILL_SPARSE,     // about one cell in eight blocked
      FILL_SCATTER     // coin flip per cell
   } fill_kind_type;

   typedef struct {
      bit            set_cols;
      int            cols;
      int            total;
      fill_kind_type fill;
      bit            known;
      square_type    result;
   } grid_plan_type;

   typedef struct {
      bit         known;
      square_type value;
   } grid_note_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [SIZE_W-1:0]     csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // grid tracker state
   logic [SIZE_W-1:0] column_setting = 11'd1;
   logic [SIZE_W-1:0] line_sizes [MAX_COLUMNS];
   logic [SIZE_W-1:0] left_run;
   logic [SIZE_W-1:0] diag_run;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   square_type        best_square;

   square_type    pending_squares [$];
   grid_note_type grid_notes [$];
   grid_plan_type plan_q [$];

   int errors       = 0;
   int cycle_count  = 0;
   int hold_off     = 0;
   bit rush         = 1'b0;
   int send_run_left = 0;
   bit send_quiet    = 1'b0;

   largest_empty_square_finder_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void clear_grid();
      left_run    = '0;
      diag_run    = '0;
      cur_row     = '0;
      cur_col     = '0;
      best_square = '0;
   endfunction

   // one cell of the maximal-square recurrence; done is set on the last cell
   function automatic void advance_grid(input logic blocked, input logic last,
                                        output bit done, output square_type report);
      int cols;
      int up;
      int side;
      cols = int'(column_setting);
      if (cols == 0) cols = 1;
      if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
      up = int'(line_sizes[cur_col]);
      if (blocked)
         side = 0;
      else if (cur_row == 0 || cur_col == 0)
         side = 1;
      else begin
         side = up;
         if (int'(left_run) < side) side = int'(left_run);
         if (int'(diag_run) < side) side = int'(diag_run);
         side = side + 1;
      end
      line_sizes[cur_col] = SIZE_W'(side);
      diag_run = SIZE_W'(up);
      left_run = SIZE_W'(side);
      if (side > int'(best_square.size)) begin
         best_square.size   = SIZE_W'(side);
         best_square.row    = cur_row;
         best_square.column = cur_col;
      end
      if (int'(cur_col) + 1 >= cols) begin
         cur_col  = '0;
         left_run = '0;
         diag_run = '0;
         if (cur_row < ROW_W'(MAX_ROWS - 1)) cur_row = cur_row + ROW_W'(1);
      end else begin
         cur_col = cur_col + COL_W'(1);
      end
      done   = last;
      report = best_square;
      if (last) clear_grid();
   endfunction

   always @(posedge clock) begin
      square_type    report;
      bit            done;
      grid_note_type note;
      if (!reset && req_tvalid && req_tready) begin
         advance_grid(req_tdata[BLOCKED_BIT], req_tlast, done, report);
         if (done) begin
            note = grid_notes.pop_front();
            pending_squares.push_back(note.known ? note.value : report);
         end
      end
   end

   always @(posedge clock) begin
      square_type want;
      square_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = square_type'(rsp_tdata[SIZE_W+ROW_W+COL_W-1:0]);
         if (pending_squares.size() == 0) begin
            $error("report beat with nothing expected: size %0d row %0d column %0d",
                   got.size, got.row, got.column);
            errors++;
         end else begin
            want = pending_squares.pop_front();
            if (got.size !== want.size) begin
               $error("square_size: expected %0d, got %0d", want.size, got.size);
               errors++;
            end
            if (got.row !== want.row) begin
               $error("bottom_row: expected %0d, got %0d", want.row, got.row);
               errors++;
            end
            if (got.column !== want.column) begin
               $error("right_column: expected %0d, got %0d", want.column, got.column);
               errors++;
            end
         end
      end
   end

   // runs with random idle gaps are mixed with runs that have no idling at all
   function automatic int draw_wait(inout int run_left, inout bit quiet);
      if (run_left == 0) begin
         quiet    = ($urandom_range(0, 3) == 0);
         run_left = int'($urandom_range(10, 40));
      end
      run_left--;
      return quiet ? 0 : int'($urandom_range(0, 8));
   endfunction

   initial begin : report_sink
      int gap;
      int run_left;
      bit quiet;
      run_left = 0;
      quiet    = 1'b0;
      wait (!reset);
      forever begin
         gap = draw_wait(run_left, quiet);
         if (hold_off != 0) begin
            gap      = hold_off;
            hold_off = 0;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_cell(input logic blocked, input logic last);
      logic [REQ_DATA_W-1:0] beat;
      int gap;
      beat = '0;
      beat[BLOCKED_BIT] = blocked;
      gap = rush ? 0 : draw_wait(send_run_left, send_quiet);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering cells and wait until every report has been taken
   task automatic settle_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_squares.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_columns(input int value);
      settle_block();
      csr_wr_data <= SIZE_W'(value);
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      column_setting = SIZE_W'(value);
   endtask

   task automatic run_grid(input fill_kind_type fill, input int total,
                           input bit known, input square_type typed);
      grid_note_type note;
      logic blocked;
      note.known = known;
      note.value = typed;
      grid_notes.push_back(note);
      for (int i = 0; i < total; i++) begin
         case (fill)
            FILL_OPEN:      blocked = 1'b0;
            FILL_WALLED:    blocked = 1'b1;
            FILL_LAST_OPEN: blocked = (i != total - 1);
            FILL_SPARSE:    blocked = ($urandom_range(0, 7) == 0);
            default:        blocked = 1'($urandom_range(0, 1));
         endcase
         send_cell(blocked, i == total - 1);
      end
   endtask

   task automatic add_plan(input bit set_cols, input int cols, input int total,
                           input fill_kind_type fill, input bit known,
                           input int size, input int row, input int column);
      grid_plan_type p;
      p.set_cols      = set_cols;
      p.cols          = cols;
      p.total         = total;
      p.fill          = fill;
      p.known         = known;
      p.result.size   = SIZE_W'(size);
      p.result.row    = ROW_W'(row);
      p.result.column = COL_W'(column);
      plan_q.push_back(p);
   endtask

   initial begin : stimulus
      int rand_cells;
      int eff_cols;
      int rows;
      int total;
      int value;
      fill_kind_type fill;
      grid_plan_type p;

      foreach (line_sizes[i]) line_sizes[i] = '0;
      clear_grid();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      //        cfg?  cols  cells fill            typed  size  row   col
      add_plan(1'b0,    1,     1, FILL_OPEN,      1'b1,    1,    0,   0);
      add_plan(1'b0,    1,     1, FILL_WALLED,    1'b1,    0,    0,   0);
      add_plan(1'b1,    0,     3, FILL_OPEN,      1'b1,    1,    0,   0);
      add_plan(1'b1,    4,    16, FILL_OPEN,      1'b1,    4,    3,   3);
      add_plan(1'b0,    4,    16, FILL_WALLED,    1'b1,    0,    0,   0);
      add_plan(1'b0,    4,    16, FILL_SCATTER,   1'b0,    0,    0,   0);
      add_plan(1'b1,    5,    10, FILL_OPEN,      1'b1,    2,    1,   1);
      add_plan(1'b1,    3,     7, FILL_OPEN,      1'b1,    2,    1,   1);
      add_plan(1'b1,    6,    32, FILL_SPARSE,    1'b0,    0,    0,   0);
      add_plan(1'b1, 2047,    12, FILL_OPEN,      1'b1,    1,    0,   0);
      add_plan(1'b1,    1,     6, FILL_LAST_OPEN, 1'b1,    1,    5,   0);
      add_plan(1'b1,    8,    20, FILL_SCATTER,   1'b0,    0,    0,   0);

      foreach (plan_q[i]) begin
         p = plan_q[i];
         if (p.set_cols) write_columns(p.cols);
         run_grid(p.fill, p.total, p.known, p.result);
      end

      // receiver stalls while tiny grids keep coming so the input backs up
      write_columns(2);
      hold_off = HOLD_CYCLES;
      rush     = 1'b1;
      for (int g = 0; g < 6; g++) run_grid(FILL_SCATTER, 4, 1'b0, '0);
      rush     = 1'b0;

      rand_cells = 0;
      while (rand_cells < 300) begin
         if (rand_cells == 0 || $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 19))
               0:       value = int'($urandom_range(0, 2047));
               1:       value = int'($urandom_range(9, 64));
               default: value = int'($urandom_range(1, 8));
            endcase
            write_columns(value);
         end
         eff_cols = int'(column_setting);
         if (eff_cols == 0) eff_cols = 1;
         if (eff_cols > MAX_COLUMNS) eff_cols = MAX_COLUMNS;
         rows  = (eff_cols > 16) ? int'($urandom_range(1, 2)) : int'($urandom_range(1, 7));
         total = eff_cols * rows;
         if ($urandom_range(0, 2) == 0) total = total - int'($urandom_range(0, eff_cols - 1));
         // wide rows are only sampled at their start to keep the run short
         if (total > 96) total = int'($urandom_range(1, 96));
         case ($urandom_range(0, 9))
            0:          fill = FILL_OPEN;
            1:          fill = FILL_WALLED;
            2, 3, 4, 5: fill = FILL_SPARSE;
            default:    fill = FILL_SCATTER;
         endcase
         run_grid(fill, total, 1'b0, '0);
         rand_cells += total;
      end

      settle_block();
      if (errors == 0 && pending_squares.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
src/lesf_pkg.sv
src/lesf_line_buf.sv
src/lesf_scan.sv
src/lesf_update.sv
src/largest_empty_square_finder_top.sv
bench/tb_largest_empty_square_finder_top.sv
